FILE: hdl/gmwf_pkg.sv
package gmwf_pkg;

    localparam int unsigned GRID_SIZE_DEF = 12;

    // widths fixed by the item fields
    localparam int unsigned POS_FW  = 4;
    localparam int unsigned CELL_W  = 2;
    localparam int unsigned HEAD_W  = 2;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned CFG_IW  = 2;
    localparam int unsigned CFG_DW  = 4;
    localparam int unsigned PC_W    = 5;

    // cell codes
    localparam logic [CELL_W-1:0] CELL_OPEN  = 2'd0;
    localparam logic [CELL_W-1:0] CELL_WALL  = 2'd1;
    localparam logic [CELL_W-1:0] CELL_ONCE  = 2'd2;
    localparam logic [CELL_W-1:0] CELL_TWICE = 2'd3;

    // headings
    localparam logic [HEAD_W-1:0] DIR_DOWN  = 2'd0;
    localparam logic [HEAD_W-1:0] DIR_RIGHT = 2'd1;
    localparam logic [HEAD_W-1:0] DIR_UP    = 2'd2;
    localparam logic [HEAD_W-1:0] DIR_LEFT  = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_DONE     = 3'd0;
    localparam logic [STAT_W-1:0] ST_MOVED    = 3'd1;
    localparam logic [STAT_W-1:0] ST_EXIT     = 3'd2;
    localparam logic [STAT_W-1:0] ST_START    = 3'd3;
    localparam logic [STAT_W-1:0] ST_STUCK    = 3'd4;
    localparam logic [STAT_W-1:0] ST_FINISHED = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_START_ROW  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_START_COL  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_START_HEAD = 2'd2;

    // reset values
    localparam logic [POS_FW-1:0] RST_START_ROW  = 4'd2;
    localparam logic [POS_FW-1:0] RST_START_COL  = 4'd0;
    localparam logic [HEAD_W-1:0] RST_START_HEAD = DIR_RIGHT;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [POS_FW-1:0] cell_row;
        logic [POS_FW-1:0] cell_col;
        logic [CELL_W-1:0] cell_data;
    } gmwf_in_t;

    typedef struct packed {
        logic [CELL_W-1:0] read_data;
        logic [POS_FW-1:0] walker_row;
        logic [POS_FW-1:0] walker_col;
        logic [HEAD_W-1:0] walker_heading;
        logic [STAT_W-1:0] status;
    } gmwf_out_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CELL_WR,
        OP_RD_REQ,
        OP_RD_TAKE,
        OP_RESTART,
        OP_RD_CUR,
        OP_MARK,
        OP_PROBE_RD,
        OP_PROBE_CHK,
        OP_SET_STUCK,
        OP_SET_EXIT,
        OP_SET_HOME,
        OP_SET_FIN
    } gmwf_op_t;

    typedef enum logic [3:0] {
        C_NEXT,
        C_JUMP,
        C_FETCH,
        C_DRAIN,
        C_FIN,
        C_HOME,
        C_EDGE,
        C_FOUND,
        C_MORE
    } gmwf_cond_t;

    typedef struct packed {
        gmwf_op_t        op;
        gmwf_cond_t      cond;
        logic [PC_W-1:0] target;
    } gmwf_uword_t;

    typedef struct packed {
        gmwf_op_t op;
        logic     in_fire;
        logic     emit_fire;
    } gmwf_ctrl_t;

    typedef struct packed {
        logic finished;
        logic home;
        logic edge_hit;
        logic found;
        logic more;
        logic slot_free;
    } gmwf_flags_t;

    // microprogram addresses; write, read, step and restart entries follow the request code
    localparam logic [PC_W-1:0] U_FETCH = 5'd0;
    localparam logic [PC_W-1:0] U_WR    = 5'd1;
    localparam logic [PC_W-1:0] U_RD    = 5'd2;
    localparam logic [PC_W-1:0] U_STEP  = 5'd3;
    localparam logic [PC_W-1:0] U_RST   = 5'd4;
    localparam logic [PC_W-1:0] U_RD2   = 5'd5;
    localparam logic [PC_W-1:0] U_CHK   = 5'd6;
    localparam logic [PC_W-1:0] U_MARK  = 5'd7;
    localparam logic [PC_W-1:0] U_EDGE  = 5'd8;
    localparam logic [PC_W-1:0] U_PROBE = 5'd9;
    localparam logic [PC_W-1:0] U_TEST  = 5'd10;
    localparam logic [PC_W-1:0] U_TURN  = 5'd11;
    localparam logic [PC_W-1:0] U_STUCK = 5'd12;
    localparam logic [PC_W-1:0] U_EXIT  = 5'd13;
    localparam logic [PC_W-1:0] U_HOME  = 5'd14;
    localparam logic [PC_W-1:0] U_FIN   = 5'd15;
    localparam logic [PC_W-1:0] U_EMIT  = 5'd16;

    function automatic gmwf_uword_t gmwf_rom(input logic [PC_W-1:0] pc);
        gmwf_uword_t w;
        case (pc)
            U_FETCH: w = '{op: OP_NOP,       cond: C_FETCH, target: U_WR};
            U_WR:    w = '{op: OP_CELL_WR,   cond: C_JUMP,  target: U_EMIT};
            U_RD:    w = '{op: OP_RD_REQ,    cond: C_JUMP,  target: U_RD2};
            U_STEP:  w = '{op: OP_RD_CUR,    cond: C_JUMP,  target: U_CHK};
            U_RST:   w = '{op: OP_RESTART,   cond: C_JUMP,  target: U_EMIT};
            U_RD2:   w = '{op: OP_RD_TAKE,   cond: C_JUMP,  target: U_EMIT};
            U_CHK:   w = '{op: OP_NOP,       cond: C_FIN,   target: U_FIN};
            U_MARK:  w = '{op: OP_MARK,      cond: C_HOME,  target: U_HOME};
            U_EDGE:  w = '{op: OP_NOP,       cond: C_EDGE,  target: U_EXIT};
            U_PROBE: w = '{op: OP_PROBE_RD,  cond: C_NEXT,  target: U_FETCH};
            U_TEST:  w = '{op: OP_PROBE_CHK, cond: C_FOUND, target: U_EMIT};
            U_TURN:  w = '{op: OP_NOP,       cond: C_MORE,  target: U_PROBE};
            U_STUCK: w = '{op: OP_SET_STUCK, cond: C_JUMP,  target: U_EMIT};
            U_EXIT:  w = '{op: OP_SET_EXIT,  cond: C_JUMP,  target: U_EMIT};
            U_HOME:  w = '{op: OP_SET_HOME,  cond: C_JUMP,  target: U_EMIT};
            U_FIN:   w = '{op: OP_SET_FIN,   cond: C_JUMP,  target: U_EMIT};
            U_EMIT:  w = '{op: OP_NOP,       cond: C_DRAIN, target: U_FETCH};
            default: w = '{op: OP_NOP,       cond: C_JUMP,  target: U_FETCH};
        endcase
        return w;
    endfunction

endpackage

FILE: hdl/grid_maze_wall_follower.sv
// channel  direction  handshake              payload
// s_       in         s_valid / s_ready      s_data   (gmwf_in_t)
// m_       out        m_valid / m_ready      m_data   (gmwf_out_t)
// cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one item at a time, run by the microprogram; a step that is not yet finished marks the
// current cell, checks for the start and the edge, then probes the neighbours in turn until
// one is open or all four are walls (stuck); each probe is a read of the cell store
// reset leaves the walker at the reset start; the cell store is not cleared
// a result waits in the output register while the next item is taken

module grid_maze_wall_follower #(
    parameter int unsigned GRID_SIZE = gmwf_pkg::GRID_SIZE_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  gmwf_pkg::gmwf_in_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output gmwf_pkg::gmwf_out_t         m_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [gmwf_pkg::CFG_IW-1:0] cfg_index,
    input  logic [gmwf_pkg::CFG_DW-1:0] cfg_data
);

    gmwf_pkg::gmwf_ctrl_t  ctrl;
    gmwf_pkg::gmwf_flags_t flags;

    assign cfg_ready = 1'b1;

    gmwf_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_req   (s_data.req_type),
        .flags   (flags),
        .s_ready (s_ready),
        .ctrl    (ctrl)
    );

    gmwf_datapath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cfg_fire  (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .flags     (flags)
    );

endmodule

FILE: hdl/gmwf_seq.sv
module gmwf_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic [1:0]           s_req,
    input  gmwf_pkg::gmwf_flags_t flags,
    output logic                 s_ready,
    output gmwf_pkg::gmwf_ctrl_t ctrl
);

    logic [gmwf_pkg::PC_W-1:0] pc_reg;
    logic [gmwf_pkg::PC_W-1:0] pc_next;
    gmwf_pkg::gmwf_uword_t     word;
    logic                      take;

    assign word = gmwf_pkg::gmwf_rom(pc_reg);

    always_comb begin
        take = 1'b0;
        case (word.cond)
            gmwf_pkg::C_NEXT:  take = 1'b0;
            gmwf_pkg::C_JUMP:  take = 1'b1;
            gmwf_pkg::C_FETCH: take = s_valid;
            gmwf_pkg::C_DRAIN: take = flags.slot_free;
            gmwf_pkg::C_FIN:   take = flags.finished;
            gmwf_pkg::C_HOME:  take = flags.home;
            gmwf_pkg::C_EDGE:  take = flags.edge_hit;
            gmwf_pkg::C_FOUND: take = flags.found;
            gmwf_pkg::C_MORE:  take = flags.more;
            default:           take = 1'b1;
        endcase
    end

    always_comb begin
        if (take) begin
            if (word.cond == gmwf_pkg::C_FETCH) begin
                pc_next = word.target + gmwf_pkg::PC_W'(s_req);
            end else begin
                pc_next = word.target;
            end
        end else if (word.cond == gmwf_pkg::C_FETCH || word.cond == gmwf_pkg::C_DRAIN) begin
            pc_next = pc_reg;
        end else begin
            pc_next = pc_reg + gmwf_pkg::PC_W'(1);
        end
    end

    assign s_ready        = (word.cond == gmwf_pkg::C_FETCH);
    assign ctrl.op        = word.op;
    assign ctrl.in_fire   = (word.cond == gmwf_pkg::C_FETCH) && s_valid;
    assign ctrl.emit_fire = (word.cond == gmwf_pkg::C_DRAIN) && flags.slot_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= gmwf_pkg::U_FETCH;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

FILE: hdl/gmwf_datapath.sv
module gmwf_datapath #(
    parameter int unsigned GRID_SIZE = gmwf_pkg::GRID_SIZE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gmwf_pkg::gmwf_ctrl_t          ctrl,
    input  gmwf_pkg::gmwf_in_t            s_data,
    input  logic                          m_ready,
    output logic                          m_valid,
    output gmwf_pkg::gmwf_out_t           m_data,
    input  logic                          cfg_fire,
    input  logic [gmwf_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [gmwf_pkg::CFG_DW-1:0]   cfg_data,
    output gmwf_pkg::gmwf_flags_t         flags
);

    localparam int unsigned IDX_W  = $clog2(GRID_SIZE);
    localparam int unsigned POS_W  = (IDX_W > gmwf_pkg::POS_FW) ? IDX_W : gmwf_pkg::POS_FW;
    localparam int unsigned DEPTH  = GRID_SIZE * GRID_SIZE;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam logic [POS_W:0] GRID_X = (POS_W+1)'(GRID_SIZE);
    localparam logic [POS_W:0] LAST_X = (POS_W+1)'(GRID_SIZE - 1);

    localparam int unsigned HW = gmwf_pkg::HEAD_W;
    localparam int unsigned CW = gmwf_pkg::CELL_W;
    localparam int unsigned FW = gmwf_pkg::POS_FW;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [POS_W:0] r,
                                                    input logic [POS_W:0] c);
        logic [ADDR_W-1:0] ra;
        logic [ADDR_W-1:0] ca;
        ra = ADDR_W'(r[IDX_W-1:0]);
        ca = ADDR_W'(c[IDX_W-1:0]);
        return ADDR_W'(ra * ADDR_W'(GRID_SIZE)) + ca;
    endfunction

    logic [CW-1:0] cell_mem [DEPTH];
    logic [CW-1:0] ram_q_reg;

    gmwf_pkg::gmwf_in_t  req_reg, req_next;
    gmwf_pkg::gmwf_out_t out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic [POS_W-1:0] cur_row_reg, cur_row_next;
    logic [POS_W-1:0] cur_col_reg, cur_col_next;
    logic [HW-1:0]    head_reg, head_next;
    logic             moved_reg, moved_next;
    logic             fin_reg, fin_next;

    logic [FW-1:0] start_row_reg, start_row_next;
    logic [FW-1:0] start_col_reg, start_col_next;
    logic [HW-1:0] start_head_reg, start_head_next;

    logic [1:0]       k_reg, k_next;
    logic [POS_W-1:0] nb_row_reg, nb_row_next;
    logic [POS_W-1:0] nb_col_reg, nb_col_next;
    logic [HW-1:0]    nb_head_reg, nb_head_next;
    logic             nb_in_reg, nb_in_next;

    logic [CW-1:0]                 rd_res_reg, rd_res_next;
    logic [gmwf_pkg::STAT_W-1:0]   status_reg, status_next;

    logic [POS_W:0]   req_row_x, req_col_x, cur_row_x, cur_col_x;
    logic             req_in, cur_in, at_start, on_edge, found;
    logic [HW-1:0]    dir;
    logic [POS_W:0]   nr_x, nc_x;
    logic [HW-1:0]    nh;
    logic             nb_in;
    logic             ram_we, ram_re;
    logic [ADDR_W-1:0] ram_addr;
    logic [CW-1:0]    ram_wdata;

    assign req_row_x = (POS_W+1)'(req_reg.cell_row);
    assign req_col_x = (POS_W+1)'(req_reg.cell_col);
    assign cur_row_x = (POS_W+1)'(cur_row_reg);
    assign cur_col_x = (POS_W+1)'(cur_col_reg);

    assign req_in   = (req_row_x < GRID_X) && (req_col_x < GRID_X);
    assign cur_in   = (cur_row_x < GRID_X) && (cur_col_x < GRID_X);
    assign at_start = (cur_row_reg == POS_W'(start_row_reg))
                   && (cur_col_reg == POS_W'(start_col_reg));
    assign on_edge  = cur_in && (cur_row_x == '0 || cur_col_x == '0
                   || cur_row_x == LAST_X || cur_col_x == LAST_X);
    assign found    = nb_in_reg && (ram_q_reg != gmwf_pkg::CELL_WALL);

    // neighbour in the probed direction; a step off the low side wraps beyond the grid
    assign dir = head_reg + k_reg;

    always_comb begin
        nr_x = cur_row_x;
        nc_x = cur_col_x;
        nh   = gmwf_pkg::DIR_DOWN;
        case (dir)
            gmwf_pkg::DIR_DOWN: begin
                nr_x = cur_row_x + (POS_W+1)'(1);
                nh   = gmwf_pkg::DIR_LEFT;
            end
            gmwf_pkg::DIR_RIGHT: begin
                nc_x = cur_col_x + (POS_W+1)'(1);
                nh   = gmwf_pkg::DIR_DOWN;
            end
            gmwf_pkg::DIR_UP: begin
                nr_x = cur_row_x - (POS_W+1)'(1);
                nh   = gmwf_pkg::DIR_RIGHT;
            end
            default: begin
                nc_x = cur_col_x - (POS_W+1)'(1);
                nh   = gmwf_pkg::DIR_UP;
            end
        endcase
    end

    assign nb_in = (nr_x < GRID_X) && (nc_x < GRID_X);

    // cell store port
    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = cell_addr(cur_row_x, cur_col_x);
        ram_wdata = (ram_q_reg == gmwf_pkg::CELL_ONCE) ? gmwf_pkg::CELL_TWICE
                                                       : gmwf_pkg::CELL_ONCE;
        case (ctrl.op)
            gmwf_pkg::OP_CELL_WR: begin
                ram_addr  = cell_addr(req_row_x, req_col_x);
                ram_we    = req_in;
                ram_wdata = req_reg.cell_data;
            end
            gmwf_pkg::OP_RD_REQ: begin
                ram_addr = cell_addr(req_row_x, req_col_x);
                ram_re   = req_in;
            end
            gmwf_pkg::OP_RD_CUR: begin
                ram_re = cur_in;
            end
            gmwf_pkg::OP_MARK: begin
                ram_we = cur_in;
            end
            gmwf_pkg::OP_PROBE_RD: begin
                ram_addr = cell_addr(nr_x, nc_x);
                ram_re   = nb_in;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ram_we) begin
            cell_mem[ram_addr] <= ram_wdata;
        end
        if (ram_re) begin
            ram_q_reg <= cell_mem[ram_addr];
        end
    end

    always_comb begin
        req_next        = req_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        head_next       = head_reg;
        moved_next      = moved_reg;
        fin_next        = fin_reg;
        start_row_next  = start_row_reg;
        start_col_next  = start_col_reg;
        start_head_next = start_head_reg;
        k_next          = k_reg;
        nb_row_next     = nb_row_reg;
        nb_col_next     = nb_col_reg;
        nb_head_next    = nb_head_reg;
        nb_in_next      = nb_in_reg;
        rd_res_next     = rd_res_reg;
        status_next     = status_reg;

        case (ctrl.op)
            gmwf_pkg::OP_RD_TAKE: begin
                rd_res_next = req_in ? ram_q_reg : gmwf_pkg::CELL_OPEN;
            end
            gmwf_pkg::OP_RESTART: begin
                cur_row_next = POS_W'(start_row_reg);
                cur_col_next = POS_W'(start_col_reg);
                head_next    = start_head_reg;
                moved_next   = 1'b0;
                fin_next     = 1'b0;
            end
            gmwf_pkg::OP_MARK: begin
                k_next = '0;
            end
            gmwf_pkg::OP_PROBE_RD: begin
                nb_row_next  = nr_x[POS_W-1:0];
                nb_col_next  = nc_x[POS_W-1:0];
                nb_head_next = nh;
                nb_in_next   = nb_in;
            end
            gmwf_pkg::OP_PROBE_CHK: begin
                k_next = k_reg + 2'd1;
                if (found) begin
                    cur_row_next = nb_row_reg;
                    cur_col_next = nb_col_reg;
                    head_next    = nb_head_reg;
                    moved_next   = 1'b1;
                    status_next  = gmwf_pkg::ST_MOVED;
                end
            end
            gmwf_pkg::OP_SET_STUCK: begin
                status_next = gmwf_pkg::ST_STUCK;
                fin_next    = 1'b1;
            end
            gmwf_pkg::OP_SET_EXIT: begin
                status_next = gmwf_pkg::ST_EXIT;
                fin_next    = 1'b1;
            end
            gmwf_pkg::OP_SET_HOME: begin
                status_next = gmwf_pkg::ST_START;
                fin_next    = 1'b1;
            end
            gmwf_pkg::OP_SET_FIN: begin
                status_next = gmwf_pkg::ST_FINISHED;
            end
            default: begin
                status_next = status_reg;
            end
        endcase

        if (ctrl.in_fire) begin
            req_next    = s_data;
            rd_res_next = gmwf_pkg::CELL_OPEN;
            status_next = gmwf_pkg::ST_DONE;
        end

        if (ctrl.emit_fire) begin
            out_next.read_data      = rd_res_reg;
            out_next.walker_row     = cur_row_reg[FW-1:0];
            out_next.walker_col     = cur_col_reg[FW-1:0];
            out_next.walker_heading = head_reg;
            out_next.status         = status_reg;
            out_valid_next          = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end

        if (cfg_fire) begin
            case (cfg_index)
                gmwf_pkg::CFG_START_ROW:  start_row_next  = cfg_data;
                gmwf_pkg::CFG_START_COL:  start_col_next  = cfg_data;
                gmwf_pkg::CFG_START_HEAD: start_head_next = cfg_data[HW-1:0];
                default:                  start_row_next  = start_row_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            cur_row_reg    <= POS_W'(gmwf_pkg::RST_START_ROW);
            cur_col_reg    <= POS_W'(gmwf_pkg::RST_START_COL);
            head_reg       <= gmwf_pkg::RST_START_HEAD;
            moved_reg      <= 1'b0;
            fin_reg        <= 1'b0;
            start_row_reg  <= gmwf_pkg::RST_START_ROW;
            start_col_reg  <= gmwf_pkg::RST_START_COL;
            start_head_reg <= gmwf_pkg::RST_START_HEAD;
            k_reg          <= '0;
        end else begin
            out_valid_reg  <= out_valid_next;
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            head_reg       <= head_next;
            moved_reg      <= moved_next;
            fin_reg        <= fin_next;
            start_row_reg  <= start_row_next;
            start_col_reg  <= start_col_next;
            start_head_reg <= start_head_next;
            k_reg          <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        out_reg     <= out_next;
        nb_row_reg  <= nb_row_next;
        nb_col_reg  <= nb_col_next;
        nb_head_reg <= nb_head_next;
        nb_in_reg   <= nb_in_next;
        rd_res_reg  <= rd_res_next;
        status_reg  <= status_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign flags.finished  = fin_reg;
    assign flags.home      = at_start && moved_reg;
    assign flags.edge_hit  = !at_start && on_edge;
    assign flags.found     = found;
    assign flags.more      = (k_reg != '0);
    assign flags.slot_free = !out_valid_reg || m_ready;

endmodule

FILE: tb/tb_top.sv
module tb_top;

    localparam int GRID         = gmwf_pkg::GRID_SIZE_DEF;
    localparam int RANDOM_ITEMS = 1750;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int MAX_STEPS    = 60;

    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_READ    = 2'd1;
    localparam logic [1:0] REQ_STEP    = 2'd2;
    localparam logic [1:0] REQ_RESTART = 2'd3;

    class walk_scoreboard;
        logic [gmwf_pkg::CELL_W-1:0] cells [GRID*GRID];
        logic [gmwf_pkg::POS_FW-1:0] start_row  = gmwf_pkg::RST_START_ROW;
        logic [gmwf_pkg::POS_FW-1:0] start_col  = gmwf_pkg::RST_START_COL;
        logic [gmwf_pkg::HEAD_W-1:0] start_head = gmwf_pkg::RST_START_HEAD;
        logic [gmwf_pkg::POS_FW-1:0] cur_row    = gmwf_pkg::RST_START_ROW;
        logic [gmwf_pkg::POS_FW-1:0] cur_col    = gmwf_pkg::RST_START_COL;
        logic [gmwf_pkg::HEAD_W-1:0] head       = gmwf_pkg::RST_START_HEAD;
        bit                          moved;
        bit                          finished;
        gmwf_pkg::gmwf_out_t         reports_q[$];
        int                          mismatches;

        function void write_start(logic [gmwf_pkg::CFG_IW-1:0] idx,
                                  logic [gmwf_pkg::CFG_DW-1:0] val);
            case (idx)
                gmwf_pkg::CFG_START_ROW:  start_row = val;
                gmwf_pkg::CFG_START_COL:  start_col = val;
                gmwf_pkg::CFG_START_HEAD: start_head = val[gmwf_pkg::HEAD_W-1:0];
                default: ;
            endcase
        endfunction

        function void accept_request(gmwf_pkg::gmwf_in_t req);
            gmwf_pkg::gmwf_out_t         rep;
            int                          nr;
            int                          nc;
            int                          here;
            int                          k;
            bit                          here_in;
            bit                          hit;
            logic [gmwf_pkg::HEAD_W-1:0] dir;
            logic [gmwf_pkg::HEAD_W-1:0] nh;
            rep = '0;
            rep.status = gmwf_pkg::ST_DONE;
            case (req.req_type)
                REQ_WRITE: begin
                    if (req.cell_row < GRID && req.cell_col < GRID)
                        cells[req.cell_row * GRID + req.cell_col] = req.cell_data;
                end
                REQ_READ: begin
                    if (req.cell_row < GRID && req.cell_col < GRID)
                        rep.read_data = cells[req.cell_row * GRID + req.cell_col];
                end
                REQ_STEP: begin
                    if (finished) begin
                        rep.status = gmwf_pkg::ST_FINISHED;
                    end else begin
                        here_in = cur_row < GRID && cur_col < GRID;
                        here = cur_row * GRID + cur_col;
                        if (here_in)
                            cells[here] = (cells[here] == gmwf_pkg::CELL_ONCE) ?
                                          gmwf_pkg::CELL_TWICE : gmwf_pkg::CELL_ONCE;
                        if (cur_row == start_row && cur_col == start_col) begin
                            if (moved) begin
                                finished = 1'b1;
                                rep.status = gmwf_pkg::ST_START;
                            end
                        end else if (here_in && (cur_row == 0 || cur_col == 0 ||
                                     cur_row == GRID - 1 || cur_col == GRID - 1)) begin
                            finished = 1'b1;
                            rep.status = gmwf_pkg::ST_EXIT;
                        end
                        if (!finished) begin
                            hit = 1'b0;
                            for (k = 0; k < 4 && !hit; k++) begin
                                dir = head + k[gmwf_pkg::HEAD_W-1:0];
                                nr = int'(cur_row);
                                nc = int'(cur_col);
                                nh = gmwf_pkg::DIR_DOWN;
                                case (dir)
                                    gmwf_pkg::DIR_DOWN: begin
                                        nr = nr + 1;
                                        nh = gmwf_pkg::DIR_LEFT;
                                    end
                                    gmwf_pkg::DIR_RIGHT: begin
                                        nc = nc + 1;
                                        nh = gmwf_pkg::DIR_DOWN;
                                    end
                                    gmwf_pkg::DIR_UP: begin
                                        nr = nr - 1;
                                        nh = gmwf_pkg::DIR_RIGHT;
                                    end
                                    default: begin
                                        nc = nc - 1;
                                        nh = gmwf_pkg::DIR_UP;
                                    end
                                endcase
                                if (nr >= 0 && nr < GRID && nc >= 0 && nc < GRID &&
                                    cells[nr * GRID + nc] != gmwf_pkg::CELL_WALL) begin
                                    hit = 1'b1;
                                    cur_row = nr[gmwf_pkg::POS_FW-1:0];
                                    cur_col = nc[gmwf_pkg::POS_FW-1:0];
                                    head = nh;
                                    moved = 1'b1;
                                    rep.status = gmwf_pkg::ST_MOVED;
                                end
                            end
                            if (!hit) begin
                                finished = 1'b1;
                                rep.status = gmwf_pkg::ST_STUCK;
                            end
                        end
                    end
                end
                default: begin
                    cur_row = start_row;
                    cur_col = start_col;
                    head = start_head;
                    moved = 1'b0;
                    finished = 1'b0;
                end
            endcase
            rep.walker_row = cur_row;
            rep.walker_col = cur_col;
            rep.walker_heading = head;
            reports_q.push_back(rep);
        endfunction

        function void compare_report(gmwf_pkg::gmwf_out_t got);
            gmwf_pkg::gmwf_out_t want;
            if (reports_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected report: rd=%0d row=%0d col=%0d head=%0d st=%0d",
                             got.read_data, got.walker_row, got.walker_col,
                             got.walker_heading, got.status);
                return;
            end
            want = reports_q.pop_front();
            if (got.read_data !== want.read_data || got.walker_row !== want.walker_row ||
                got.walker_col !== want.walker_col ||
                got.walker_heading !== want.walker_heading || got.status !== want.status) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected rd=%0d row=%0d col=%0d head=%0d st=%0d",
                             want.read_data, want.walker_row, want.walker_col,
                             want.walker_heading, want.status);
                    $display("          actual   rd=%0d row=%0d col=%0d head=%0d st=%0d",
                             got.read_data, got.walker_row, got.walker_col,
                             got.walker_heading, got.status);
                end
            end
        endfunction
    endclass

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    gmwf_pkg::gmwf_in_t            s_data    = '0;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    gmwf_pkg::gmwf_out_t           m_data;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [gmwf_pkg::CFG_IW-1:0]   cfg_index = '0;
    logic [gmwf_pkg::CFG_DW-1:0]   cfg_data  = '0;

    walk_scoreboard sb = new();
    bit             steady = 1'b0;
    int             counted = 0;
    int             cycles = 0;

    grid_maze_wall_follower i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles = cycles + 1;
        if (aresetn && m_valid && m_ready)
            sb.compare_report(m_data);
        if (steady)
            m_ready <= 1'b1;
        else
            m_ready <= ($urandom_range(99) >= 30);
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic issue(input logic [1:0] kind, input int row, input int col, input int data);
        gmwf_pkg::gmwf_in_t req;
        req.req_type = kind;
        req.cell_row = row[gmwf_pkg::POS_FW-1:0];
        req.cell_col = col[gmwf_pkg::POS_FW-1:0];
        req.cell_data = data[gmwf_pkg::CELL_W-1:0];
        if (!steady) begin
            while ($urandom_range(99) < 30) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (!s_ready);
        sb.accept_request(req);
        if (!(kind == REQ_WRITE && (row >= GRID || col >= GRID)))
            counted++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.reports_q.size() != 0);
    endtask

    task automatic set_start(input int row, input int col, input int hd);
        logic [gmwf_pkg::CFG_IW-1:0] idx [3];
        logic [gmwf_pkg::CFG_DW-1:0] val [3];
        int                          i;
        idx = '{gmwf_pkg::CFG_START_ROW, gmwf_pkg::CFG_START_COL, gmwf_pkg::CFG_START_HEAD};
        val = '{row[gmwf_pkg::CFG_DW-1:0], col[gmwf_pkg::CFG_DW-1:0],
                hd[gmwf_pkg::CFG_DW-1:0]};
        settle();
        for (i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.write_start(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_pos();
        return ($urandom_range(99) < 10) ? $urandom_range(15) : $urandom_range(GRID - 1);
    endfunction

    task automatic load_maze(input int wall_pct);
        int r;
        int c;
        int data;
        for (r = 0; r < GRID; r++) begin
            for (c = 0; c < GRID; c++) begin
                if (r == sb.start_row && c == sb.start_col)
                    data = int'(gmwf_pkg::CELL_OPEN);
                else if (r == 0 || c == 0 || r == GRID - 1 || c == GRID - 1)
                    data = ($urandom_range(99) < 8) ? int'(gmwf_pkg::CELL_OPEN)
                                                    : int'(gmwf_pkg::CELL_WALL);
                else if ($urandom_range(99) < wall_pct)
                    data = int'(gmwf_pkg::CELL_WALL);
                else if ($urandom_range(3) == 0)
                    data = $urandom_range(int'(gmwf_pkg::CELL_ONCE),
                                          int'(gmwf_pkg::CELL_TWICE));
                else
                    data = int'(gmwf_pkg::CELL_OPEN);
                issue(REQ_WRITE, r, c, data);
            end
        end
    endtask

    task automatic walk(input int extra, input int noise_pct);
        int n;
        n = 0;
        while (!sb.finished && n < MAX_STEPS) begin
            if ($urandom_range(99) < noise_pct)
                issue(2'($urandom_range(3)), $urandom_range(15), $urandom_range(15),
                      $urandom_range(3));
            issue(REQ_STEP, $urandom_range(15), $urandom_range(15), $urandom_range(3));
            n++;
        end
        repeat (extra)
            issue(REQ_STEP, $urandom_range(15), $urandom_range(15), $urandom_range(3));
    endtask

    initial begin
        int episode;
        int target;
        int row;
        int col;
        int data;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // whole store loaded before anything reads it
        load_maze(25);
        issue(REQ_WRITE, 2, 1, int'(gmwf_pkg::CELL_OPEN));
        issue(REQ_READ, 0, 0, 0);
        issue(REQ_READ, GRID - 1, GRID - 1, 0);
        issue(REQ_READ, 15, 15, 3);
        issue(REQ_READ, GRID, 0, 0);
        issue(REQ_WRITE, 13, 2, int'(gmwf_pkg::CELL_TWICE));
        issue(REQ_WRITE, 5, 5, int'(gmwf_pkg::CELL_TWICE));
        issue(REQ_READ, 5, 5, 0);
        walk(1, 0);
        issue(REQ_RESTART, 0, 0, 0);
        issue(REQ_STEP, 0, 0, 0);

        // short loop back to the start
        set_start(5, 5, int'(gmwf_pkg::DIR_RIGHT));
        issue(REQ_WRITE, 5, 5, int'(gmwf_pkg::CELL_OPEN));
        issue(REQ_WRITE, 5, 6, int'(gmwf_pkg::CELL_OPEN));
        issue(REQ_WRITE, 6, 6, int'(gmwf_pkg::CELL_WALL));
        issue(REQ_WRITE, 5, 7, int'(gmwf_pkg::CELL_WALL));
        issue(REQ_WRITE, 4, 6, int'(gmwf_pkg::CELL_WALL));
        issue(REQ_RESTART, 0, 0, 0);
        walk(1, 0);

        // boxed in
        issue(REQ_WRITE, 5, 6, int'(gmwf_pkg::CELL_WALL));
        issue(REQ_WRITE, 4, 5, int'(gmwf_pkg::CELL_WALL));
        issue(REQ_WRITE, 6, 5, int'(gmwf_pkg::CELL_WALL));
        issue(REQ_WRITE, 5, 4, int'(gmwf_pkg::CELL_WALL));
        issue(REQ_RESTART, 0, 0, 0);
        walk(1, 0);

        // start outside the grid
        set_start(GRID, 3, int'({2'b11, gmwf_pkg::DIR_UP}));
        issue(REQ_WRITE, GRID - 1, 3, int'(gmwf_pkg::CELL_OPEN));
        issue(REQ_RESTART, 0, 0, 0);
        walk(1, 0);
        set_start(15, 15, int'(gmwf_pkg::DIR_LEFT));
        issue(REQ_RESTART, 0, 0, 0);
        walk(1, 0);

        target = counted + RANDOM_ITEMS;
        episode = 0;
        while (counted < target) begin
            episode++;
            steady = (episode >= 20 && episode < 32);
            if ($urandom_range(5) == 0) begin
                case ($urandom_range(6))
                    0: begin row = 0; col = 0; end
                    1: begin row = GRID - 1; col = GRID - 1; end
                    2: begin row = 15; col = $urandom_range(15); end
                    3: begin row = $urandom_range(GRID - 1); col = 0; end
                    4: begin row = 0; col = $urandom_range(GRID - 1); end
                    default: begin
                        row = $urandom_range(GRID - 1);
                        col = $urandom_range(GRID - 1);
                    end
                endcase
                set_start(row, col, $urandom_range(15));
            end
            if (episode % 15 == 7)
                settle();
            if (episode % 40 == 0)
                load_maze($urandom_range(10, 40));
            repeat ($urandom_range(1, 8)) begin
                data = ($urandom_range(99) < 35) ? int'(gmwf_pkg::CELL_WALL)
                                                 : int'($urandom_range(3));
                issue(REQ_WRITE, pick_pos(), pick_pos(), data);
            end
            repeat ($urandom_range(0, 3))
                issue(REQ_READ, pick_pos(), pick_pos(), $urandom_range(3));
            if ($urandom_range(9) != 0)
                issue(REQ_RESTART, $urandom_range(15), $urandom_range(15), $urandom_range(3));
            walk($urandom_range(2), 4);
        end
        steady = 1'b0;

        settle();
        repeat (40) @(posedge aclk);
        if (sb.mismatches == 0 && sb.reports_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
